// ===== rtl/core/tnrf_pkg.sv =====
package tnrf_pkg;

	localparam logic [7:0] TN_NOP  = 8'd241;
	localparam logic [7:0] TN_GA   = 8'd249;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_IAC  = 8'd255;

	localparam logic [7:0] OPT_BINARY = 8'd0;
	localparam logic [7:0] OPT_ECHO   = 8'd1;
	localparam logic [7:0] OPT_SGA    = 8'd3;

	localparam logic [7:0] VERB_NONE = 8'd0;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic DEST_HOST = 1'b0;
	localparam logic DEST_PEER = 1'b1;

	localparam logic CFG_FILTER_ENABLE = 1'b0;
	localparam logic CFG_SEND_OPENING  = 1'b1;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] LAST_STEP_DATA  = 4'd0;
	localparam logic [STEP_W-1:0] LAST_STEP_REPLY = 4'd2;
	localparam logic [STEP_W-1:0] LAST_STEP_OPEN  = 4'd8;

	typedef enum logic [2:0] {
		ST_DATA = 3'd0,
		ST_IAC  = 3'd1,
		ST_WILL = 3'd2,
		ST_WONT = 3'd3,
		ST_DO   = 3'd4,
		ST_DONT = 3'd5
	} parse_state_t;

	typedef enum logic [1:0] {
		JOB_DATA  = 2'd0,
		JOB_REPLY = 2'd1,
		JOB_OPEN  = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
	} job_t;

	function automatic logic [7:0] reply_verb(parse_state_t st, logic [7:0] opt);
		logic [7:0] verb;
		verb = VERB_NONE;
		if (opt == OPT_BINARY) begin
			verb = (st == ST_DO || st == ST_DONT) ? TN_WILL : TN_DO;
		end else if (opt == OPT_ECHO) begin
			if (st == ST_WILL) verb = TN_DONT;
			else if (st == ST_DONT) verb = TN_WILL;
		end else if (opt == OPT_SGA) begin
			if (st == ST_DONT) verb = TN_WILL;
			else if (st == ST_WILL) verb = TN_DO;
			else if (st == ST_WONT) verb = TN_DONT;
		end else begin
			verb = (st == ST_WILL) ? TN_DONT : TN_WONT;
		end
		return verb;
	endfunction

	function automatic logic [7:0] open_byte(logic [STEP_W-1:0] step);
		logic [7:0] b;
		unique case (step)
			4'd0, 4'd3, 4'd6: b = TN_IAC;
			4'd1: b = TN_DO;
			4'd2: b = OPT_BINARY;
			4'd4, 4'd7: b = TN_WILL;
			4'd5: b = OPT_ECHO;
			4'd8: b = OPT_SGA;
			default: b = TN_IAC;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/tnrf_if.sv =====
interface tnrf_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface tnrf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_dest;
	logic       last;

	modport source (output valid, output out_byte, output out_dest, output last, input ready);
	modport sink (input valid, input out_byte, input out_dest, input last, output ready);
endinterface

interface tnrf_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tnrf_front.sv =====
module tnrf_front
	import tnrf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	tnrf_in_if.sink rx,
	input  logic   filter_en,
	input  logic   send_open,
	input  logic   full,
	output logic   push,
	output job_t   push_job
);

	parse_state_t state_q;
	parse_state_t state_d;
	logic         accept;
	logic [7:0]   verb;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;
	assign verb     = reply_verb(state_q, rx.rx_byte);

	always_comb begin
		state_d = state_q;
		if (rx.command == CMD_START) begin
			state_d = ST_DATA;
		end else if (filter_en) begin
			unique case (state_q)
				ST_DATA: if (rx.rx_byte == TN_IAC) state_d = ST_IAC;
				ST_IAC: begin
					priority case (rx.rx_byte)
						TN_WILL: state_d = ST_WILL;
						TN_WONT: state_d = ST_WONT;
						TN_DO:   state_d = ST_DO;
						TN_DONT: state_d = ST_DONT;
						default: state_d = ST_DATA;
					endcase
				end
				default: state_d = ST_DATA;
			endcase
		end
	end

	always_comb begin
		push            = 1'b0;
		push_job.kind   = JOB_DATA;
		push_job.byte_a = rx.rx_byte;
		push_job.byte_b = rx.rx_byte;
		if (rx.command == CMD_START) begin
			push_job.kind = JOB_OPEN;
			push          = filter_en && send_open;
		end else if (!filter_en) begin
			push = 1'b1;
		end else begin
			unique case (state_q)
				ST_DATA: push = (rx.rx_byte != TN_IAC);
				ST_IAC:  push = (rx.rx_byte == TN_IAC);
				ST_WILL, ST_WONT, ST_DO, ST_DONT: begin
					push_job.kind   = JOB_REPLY;
					push_job.byte_a = verb;
					push            = (verb != VERB_NONE);
				end
				default: push = 1'b0;
			endcase
		end
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/tnrf_queue.sv =====
module tnrf_queue
	import tnrf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("queue count out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push && cnt_q == CNT_W'(1) |=> empty) else $error("queue did not drain");

endmodule

// ===== rtl/core/tnrf_back.sv =====
module tnrf_back
	import tnrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        empty,
	output logic        pop,
	tnrf_out_if.source  tx
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] last_step;
	logic              load;
	logic              advance;
	logic              at_last;
	logic [7:0]        sel_byte;
	logic              sel_dest;
	logic              out_v_q;
	logic [7:0]        out_byte_q;
	logic              out_dest_q;
	logic              out_last_q;

	always_comb begin
		unique case (head.kind)
			JOB_DATA: begin
				last_step = LAST_STEP_DATA;
				sel_byte  = head.byte_a;
				sel_dest  = DEST_HOST;
			end
			JOB_REPLY: begin
				last_step = LAST_STEP_REPLY;
				sel_dest  = DEST_PEER;
				if (step_q == STEP_W'(0)) sel_byte = TN_IAC;
				else if (step_q == STEP_W'(1)) sel_byte = head.byte_a;
				else sel_byte = head.byte_b;
			end
			JOB_OPEN: begin
				last_step = LAST_STEP_OPEN;
				sel_byte  = open_byte(step_q);
				sel_dest  = DEST_PEER;
			end
			default: begin
				last_step = LAST_STEP_DATA;
				sel_byte  = head.byte_a;
				sel_dest  = DEST_HOST;
			end
		endcase
	end

	assign load    = !out_v_q || tx.ready;
	assign advance = load && !empty;
	assign at_last = (step_q == last_step);
	assign pop     = advance && at_last;

	assign tx.valid    = out_v_q;
	assign tx.out_byte = out_byte_q;
	assign tx.out_dest = out_dest_q;
	assign tx.last     = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (load) out_v_q <= !empty;
			if (advance) step_q <= at_last ? '0 : step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= sel_byte;
			out_dest_q <= sel_dest;
			out_last_q <= at_last;
		end
	end

	a_step_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 |-> !empty) else $error("job left the queue before its last byte");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP_OPEN) else $error("byte step out of range");

endmodule

// ===== rtl/core/telnet_receive_filter_core.sv =====
// Telnet receive filter: each item on data_in is a received byte or a
// connection start, and each item on data_out is one byte for the host or
// one negotiation byte for the peer, with last set on the final byte caused
// by an input item. The front end parses one input item per cycle and posts
// a job into a queue of QUEUE_DEPTH entries; the back end turns each job into
// bytes, one per cycle through a registered output while data_out is ready.
// So plain data flows at one item per cycle, an option reply is three bytes
// and the opening negotiation nine; input stalls only once the queue is full.
// Items that cause no result leave nothing on data_out. Configuration writes
// on cfg are accepted every cycle and should be made while the block is idle.
module telnet_receive_filter_core
	import tnrf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tnrf_in_if.sink      data_in,
	tnrf_out_if.source   data_out,
	tnrf_cfg_if.sink     cfg
);

	logic filter_en_q;
	logic send_open_q;
	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t push_job;
	job_t head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b0;
			send_open_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FILTER_ENABLE: filter_en_q <= cfg.data;
				CFG_SEND_OPENING:  send_open_q <= cfg.data;
				default:           filter_en_q <= filter_en_q;
			endcase
		end
	end

	tnrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (data_in),
		.filter_en (filter_en_q),
		.send_open (send_open_q),
		.full      (full),
		.push      (push),
		.push_job  (push_job)
	);

	tnrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	tnrf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tx     (data_out)
	);

endmodule
